// ----- rtl/core/irc_pkg.sv -----
// Package for the interval reservation checker.
// Holds the beat structs, status codes, FSM state and ctrl/datapath command types.
package irc_pkg;

  localparam int MaxRangesDef = 32;
  localparam int TimeBitsDef  = 32;
  localparam int InTimeW      = 32;
  localparam int EntW         = 6;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef struct packed {
    logic [InTimeW-1:0] range_start;
    logic [InTimeW-1:0] range_end;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [EntW-1:0] entries_used;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CMP  = 2'd1,
    S_UPD  = 2'd2
  } state_t;

  typedef struct packed {
    logic load;
    logic cmp;
    logic upd;
  } cmd_t;

endpackage

// ----- rtl/core/interval_reservation_checker_top.sv -----
// Channel   Signals                         Beat
// in        in_valid / in_ready / in_req    one reservation request
// out       out_valid / out_ready / out_rsp one status + entry count
//
// Each request goes through three steps: load, parallel compare over all slots, update.
// Next request is taken in the cycle after the update; the output register
// lets that happen while the previous result waits. A stalled output holds
// the update step. Synchronous reset empties the table at once.
// Top level of the interval reservation checker; uses irc_pkg, irc_ctrl, irc_dp.
module interval_reservation_checker_top #(
  parameter int MAX_RANGES = irc_pkg::MaxRangesDef,
  parameter int TIME_BITS  = irc_pkg::TimeBitsDef
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  irc_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_ready,
  output irc_pkg::rsp_t out_rsp
);
  import irc_pkg::*;

  cmd_t cmd;
  logic out_free;

  irc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .cmd      (cmd)
  );

  irc_dp #(
    .MAX_RANGES (MAX_RANGES),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_req    (in_req),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while busy");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result before compare step");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.cmp, cmd.upd}))
    else $error("overlapping datapath commands");

endmodule

// ----- rtl/core/irc_ctrl.sv -----
// Controller FSM of the interval reservation checker.
// Uses irc_pkg; sequences load, compare and update in the datapath.
module irc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_free,
  output irc_pkg::cmd_t cmd
);
  import irc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          cmd.upd    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/irc_dp.sv -----
// Datapath of the interval reservation checker: range table, parallel
// compare, merge/insert update and output register. Uses irc_pkg.
module irc_dp #(
  parameter int MAX_RANGES = irc_pkg::MaxRangesDef,
  parameter int TIME_BITS  = irc_pkg::TimeBitsDef
) (
  input  logic          clk,
  input  logic          rst,
  input  irc_pkg::cmd_t cmd,
  input  irc_pkg::req_t in_req,
  output logic          out_free,
  output logic          out_valid,
  input  logic          out_ready,
  output irc_pkg::rsp_t out_rsp
);
  import irc_pkg::*;

  localparam int CntW = $clog2(MAX_RANGES + 1);

  logic [TIME_BITS-1:0]  slot_start [MAX_RANGES];
  logic [TIME_BITS-1:0]  slot_end   [MAX_RANGES];
  logic [MAX_RANGES-1:0] slot_valid;
  logic [CntW-1:0]       used_count;

  logic [TIME_BITS-1:0]  req_s, req_e;
  logic [MAX_RANGES-1:0] left_hit, right_hit, free_hit;
  logic                  ovl, bad, full;
  logic [TIME_BITS-1:0]  right_end;

  logic [MAX_RANGES-1:0] ovl_c, left_c, right_c, free_c;
  logic [TIME_BITS-1:0]  right_end_c;
  logic                  do_left, do_right;
  status_t               st;

  always_comb begin
    right_end_c = '0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      ovl_c[i]   = slot_valid[i] && (slot_start[i] < req_e) && (req_s < slot_end[i]);
      left_c[i]  = slot_valid[i] && (slot_end[i] == req_s);
      right_c[i] = slot_valid[i] && (slot_start[i] == req_e);
      if (right_c[i]) begin
        right_end_c = right_end_c | slot_end[i];
      end
    end
    free_c = ~slot_valid & (slot_valid + MAX_RANGES'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_s <= TIME_BITS'({32'd0, in_req.range_start});
      req_e <= TIME_BITS'({32'd0, in_req.range_end});
    end
    if (cmd.cmp) begin
      bad       <= req_s >= req_e;
      ovl       <= |ovl_c;
      full      <= &slot_valid;
      left_hit  <= left_c;
      right_hit <= right_c;
      free_hit  <= free_c;
      right_end <= right_end_c;
    end
  end

  assign do_left  = |left_hit;
  assign do_right = |right_hit;

  always_comb begin
    if (bad) begin
      st = ST_INVALID;
    end else if (ovl) begin
      st = ST_OVERLAP;
    end else if (!do_left && !do_right && full) begin
      st = ST_FULL;
    end else begin
      st = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      used_count <= '0;
    end else if (cmd.upd && st == ST_OK) begin
      if (do_left && do_right) begin
        slot_valid <= slot_valid & ~right_hit;
        used_count <= used_count - CntW'(1);
      end else if (!do_left && !do_right) begin
        slot_valid <= slot_valid | free_hit;
        used_count <= used_count + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && st == ST_OK) begin
      for (int i = 0; i < MAX_RANGES; i++) begin
        if (do_left) begin
          if (left_hit[i]) begin
            slot_end[i] <= do_right ? right_end : req_e;
          end
        end else if (do_right) begin
          if (right_hit[i]) begin
            slot_start[i] <= req_s;
          end
        end else if (free_hit[i]) begin
          slot_start[i] <= req_s;
          slot_end[i]   <= req_e;
        end
      end
    end
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.upd) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_rsp.status <= st;
      if (st != ST_OK) begin
        out_rsp.entries_used <= EntW'(used_count);
      end else if (do_left && do_right) begin
        out_rsp.entries_used <= EntW'(used_count - CntW'(1));
      end else if (!do_left && !do_right) begin
        out_rsp.entries_used <= EntW'(used_count + CntW'(1));
      end else begin
        out_rsp.entries_used <= EntW'(used_count);
      end
    end
  end

endmodule

// ----- bench/tb.sv -----
// Testbench for interval_reservation_checker_top: drives reservation requests
// and checks each response against a behavioral booking table. Uses irc_pkg.
`timescale 1ns / 100ps

module tb;
  import irc_pkg::*;

  localparam int NumSlots = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_rsp;

  always #5 clk = ~clk;

  interval_reservation_checker_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp)
  );

  logic [31:0] book_lo [NumSlots];
  logic [31:0] book_hi [NumSlots];
  logic        book_vld [NumSlots];
  logic [5:0]  book_cnt;
  rsp_t        pending_rsp [$];
  int          mismatches = 0;
  int          send_idle = 13;
  int          recv_idle = 87;

  function automatic status_t book_range(logic [31:0] s, logic [31:0] e);
    int left, right, free_slot;
    left = -1;
    right = -1;
    free_slot = -1;
    if (s >= e) return ST_INVALID;
    for (int i = 0; i < NumSlots; i++) begin
      if (!book_vld[i]) begin
        if (free_slot < 0) free_slot = i;
        continue;
      end
      if (book_lo[i] < e && s < book_hi[i]) return ST_OVERLAP;
      if (book_hi[i] == s) left = i;
      if (book_lo[i] == e) right = i;
    end
    if (left >= 0 && right >= 0) begin
      book_hi[left] = book_hi[right];
      book_vld[right] = 1'b0;
      book_cnt--;
    end else if (left >= 0) begin
      book_hi[left] = e;
    end else if (right >= 0) begin
      book_lo[right] = s;
    end else begin
      if (free_slot < 0) return ST_FULL;
      book_lo[free_slot] = s;
      book_hi[free_slot] = e;
      book_vld[free_slot] = 1'b1;
      book_cnt++;
    end
    return ST_OK;
  endfunction

  task automatic send_request(logic [31:0] s, logic [31:0] e, bit has_fixed,
                              status_t fixed_st, logic [5:0] fixed_cnt);
    rsp_t r;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= '{range_start: s, range_end: e};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r.status = book_range(s, e);
    r.entries_used = book_cnt;
    if (has_fixed) begin
      r.status = fixed_st;
      r.entries_used = fixed_cnt;
    end
    pending_rsp.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", out_rsp);
        end else begin
          if (out_rsp !== pending_rsp[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("response mismatch: expected %p, got %p", pending_rsp[0], out_rsp);
          end
          void'(pending_rsp.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  typedef struct {
    logic [31:0] s;
    logic [31:0] e;
    bit          has_fixed;
    status_t     st;
    logic [5:0]  cnt;
  } stim_row_t;

  stim_row_t directed [] = '{
    '{32'd10, 32'd10, 1, ST_INVALID, 6'd0},
    '{32'd20, 32'd10, 1, ST_INVALID, 6'd0},
    '{32'hFFFFFFFF, 32'd0, 1, ST_INVALID, 6'd0},
    '{32'd0, 32'd1, 1, ST_OK, 6'd1},
    '{32'd100, 32'd200, 1, ST_OK, 6'd2},
    '{32'd150, 32'd160, 1, ST_OVERLAP, 6'd2},
    '{32'd50, 32'd101, 1, ST_OVERLAP, 6'd2},
    '{32'd199, 32'd300, 1, ST_OVERLAP, 6'd2},
    '{32'd200, 32'd250, 0, ST_OK, 6'd0},
    '{32'd80, 32'd100, 0, ST_OK, 6'd0},
    '{32'd1, 32'd80, 0, ST_OK, 6'd0},
    '{32'hFFFFFFF0, 32'hFFFFFFFF, 0, ST_OK, 6'd0},
    '{32'd0, 32'hFFFFFFFF, 0, ST_OK, 6'd0},
    '{32'h55555555, 32'hAAAAAAAA, 0, ST_OK, 6'd0}
  };

  initial begin
    logic [31:0] s, e, len;
    for (int i = 0; i < NumSlots; i++) begin
      book_lo[i] = '0;
      book_hi[i] = '0;
      book_vld[i] = 1'b0;
    end
    book_cnt = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i])
      send_request(directed[i].s, directed[i].e, directed[i].has_fixed,
                   directed[i].st, directed[i].cnt);
    // fill the table with gaps to reach table_full, then bridge gaps
    for (int i = 0; i < 34; i++)
      send_request(1000 + 20 * i, 1010 + 20 * i, 0, ST_OK, 6'd0);
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 1336 / 3; i++) begin
        if (k == 1) begin
          send_idle = 87;
          recv_idle = 13;
        end else if (k == 2) begin
          send_idle = 0;
          recv_idle = 0;
        end
        case ($urandom_range(9))
          0: begin
            s = $urandom;
            e = $urandom;
          end
          1, 2: begin
            s = $urandom_range(2000, 0);
            e = s + $urandom_range(3, 0);
          end
          3: begin
            s = 1010 + 20 * $urandom_range(33);
            e = s + 10;
          end
          default: begin
            len = $urandom_range(40, 1);
            s = $urandom_range(4000, 0) + ($urandom_range(1) ? 32'hFFFF0000 : 0);
            e = s + len;
          end
        endcase
        send_request(s, e, 0, ST_OK, 6'd0);
        if ($urandom_range(149) == 0) begin
          in_valid <= 1'b0;
          while (pending_rsp.size() != 0) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
    fork
      begin
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
      end
      begin
        repeat (2000) @(posedge clk);
      end
    join_any
    if (pending_rsp.size() == 0 && mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
